/* design/u16u8_pkg.sv */
// Shared types, constants and the UTF-8 encode function for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other design file but u16u8_if imports this package.
package u16u8_pkg;

  localparam int ByteW       = 8;
  localparam int HighBitsW   = 10;
  localparam int CodePointW  = 21;
  localparam int MaxBytes    = 4;
  localparam int ByteIdxW    = 2;
  localparam int QueueDepthDefault = 4;

  // Surrogate prefixes (top six bits of a code unit)
  localparam logic [5:0] HighSurrPrefix = 6'b110110;
  localparam logic [5:0] LowSurrPrefix  = 6'b110111;

  // Offset of the supplementary planes, in units of 1024 code points
  localparam logic [HighBitsW:0] SuppPlaneBase = 11'd64;

  // One unit of work for the back end: up to four bytes, or a marker
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] byte_seq;   // first byte in entry 0
    logic [ByteIdxW-1:0]            last_idx;   // index of the final result
    logic                           has_byte;
    logic                           str_end;
    logic                           bad;
  } job_t;

  function automatic job_t u16u8_encode(input logic [CodePointW-1:0] cp,
                                        input logic last);
    job_t j;
    j          = '0;
    j.has_byte = 1'b1;
    j.str_end  = last;
    if (cp < 21'h80) begin
      j.byte_seq[0] = cp[7:0];
      j.last_idx    = 2'd0;
    end else if (cp < 21'h800) begin
      j.byte_seq[0] = {3'b110, cp[10:6]};
      j.byte_seq[1] = {2'b10, cp[5:0]};
      j.last_idx    = 2'd1;
    end else if (cp < 21'h10000) begin
      j.byte_seq[0] = {4'b1110, cp[15:12]};
      j.byte_seq[1] = {2'b10, cp[11:6]};
      j.byte_seq[2] = {2'b10, cp[5:0]};
      j.last_idx    = 2'd2;
    end else begin
      j.byte_seq[0] = {5'b11110, cp[20:18]};
      j.byte_seq[1] = {2'b10, cp[17:12]};
      j.byte_seq[2] = {2'b10, cp[11:6]};
      j.byte_seq[3] = {2'b10, cp[5:0]};
      j.last_idx    = 2'd3;
    end
    return j;
  endfunction

  function automatic job_t u16u8_marker(input logic str_end, input logic bad);
    job_t j;
    j         = '0;
    j.str_end = str_end;
    j.bad     = bad;
    return j;
  endfunction

endpackage

/* design/u16u8_if.sv */
// Valid/ready stream interfaces for the transcoder: UTF-16 units in, UTF-8 results out.
// Depends on nothing; used by the top level and its sub-blocks.
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_last;

  modport source (output valid, code_unit, unit_last, input ready);
  modport sink   (input valid, code_unit, unit_last, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       string_end;
  logic       bad_pair;

  modport source (output valid, out_byte, has_byte, run_last, string_end, bad_pair,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, run_last, string_end, bad_pair,
                  output ready);
endinterface

/* design/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder. A unit accepted by the front end goes into the job queue; the
// back end moves its results from the queue head into the output register, which sets the
// throughput of one result per cycle unless the output stalls: a unit yields 1 to 4 results (a
// pair 4, a held high surrogate none). Input is taken whenever the job queue has room.
// Synchronous reset rst clears the surrogate hold, the discard flag, the queue and the output.
// Depends on u16u8_pkg, u16u8_if and the front, queue and back sub-blocks.
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  u16u8_unit_if.sink    units,
  u16u8_byte_if.source  bytes
);

  // Front end -> queue: one job per unit that yields results
  logic push;
  job_t push_job;
  logic q_full;

  // Queue -> back end: head job, drained one result per transfer
  logic q_empty;
  logic pop;
  job_t head;

  // Classify units, pair surrogates, hold discard state
  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .units    (units),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple the two sides so input keeps flowing while bytes drain
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // Emit the job's bytes or marker, one transfer per cycle while the output is not stalled
  u16u8_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .bytes   (bytes)
  );

endmodule

/* design/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates, tracks discard state, builds jobs.
// Depends on u16u8_pkg and u16u8_unit_if.
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  u16u8_unit_if.sink         units,
  input  logic               q_full,
  output logic               push,
  output job_t               push_job
);

  logic [HighBitsW-1:0] held_high_bits, held_high_bits_next;
  logic                 held_valid, held_valid_next;
  logic                 discarding, discarding_next;

  logic                 take;
  logic                 is_high, is_low;
  logic [HighBitsW:0]   plane;
  logic [CodePointW-1:0] pair_cp;

  assign units.ready = !q_full;
  assign take        = units.valid && units.ready;

  assign is_high = (units.code_unit[15:10] == HighSurrPrefix);
  assign is_low  = (units.code_unit[15:10] == LowSurrPrefix);
  assign plane   = {1'b0, held_high_bits} + SuppPlaneBase;
  assign pair_cp = {plane, units.code_unit[9:0]};

  always_comb begin
    held_high_bits_next = held_high_bits;
    held_valid_next     = held_valid;
    discarding_next     = discarding;
    push                = 1'b0;
    push_job            = u16u8_encode({5'd0, units.code_unit}, units.unit_last);
    if (take) begin
      priority if (discarding) begin
        // drop units until the end of the string, then mark the end
        push            = units.unit_last;
        push_job        = u16u8_marker(1'b1, 1'b0);
        discarding_next = !units.unit_last;
      end else if (held_valid) begin
        held_valid_next     = 1'b0;
        held_high_bits_next = '0;
        push                = 1'b1;
        if (is_low) begin
          push_job = u16u8_encode(pair_cp, units.unit_last);
        end else begin
          push_job        = u16u8_marker(units.unit_last, 1'b1);
          discarding_next = !units.unit_last;
        end
      end else if (is_high) begin
        if (units.unit_last) begin
          // lone high surrogate at the end: drop it, keep the end marker
          push     = 1'b1;
          push_job = u16u8_marker(1'b1, 1'b0);
        end else begin
          held_valid_next     = 1'b1;
          held_high_bits_next = units.code_unit[HighBitsW-1:0];
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      held_valid     <= 1'b0;
      discarding     <= 1'b0;
    end else begin
      held_high_bits <= held_high_bits_next;
      held_valid     <= held_valid_next;
      discarding     <= discarding_next;
    end
  end

endmodule

/* design/u16u8_queue.sv */
// Small job queue between the front and back ends of the transcoder.
// Depends on u16u8_pkg.
module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            store [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/u16u8_back.sv */
// Back end: walks the bytes of the queue head and drives the registered output channel.
// Depends on u16u8_pkg and u16u8_byte_if.
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  job_t          head,
  output logic          pop,
  u16u8_byte_if.source  bytes
);

  logic [ByteIdxW-1:0] idx;
  logic                o_valid;
  logic [ByteW-1:0]    o_byte;
  logic                o_has, o_run_last, o_str_end, o_bad;
  logic                advance, emit, at_end;

  assign advance = !o_valid || bytes.ready;
  assign emit    = advance && !q_empty;
  assign at_end  = (idx == head.last_idx);
  assign pop     = emit && at_end;

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte     <= head.byte_seq[idx];
      o_has      <= head.has_byte;
      o_run_last <= at_end;
      o_str_end  <= at_end && head.str_end;
      o_bad      <= head.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (advance) begin
        o_valid <= !q_empty;
      end
      if (emit) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
    end
  end

  assign bytes.valid      = o_valid;
  assign bytes.out_byte   = o_byte;
  assign bytes.has_byte   = o_has;
  assign bytes.run_last   = o_run_last;
  assign bytes.string_end = o_str_end;
  assign bytes.bad_pair   = o_bad;

endmodule
